[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/adrc_pkg.sv]
`timescale 1ns / 1ps

package adrc_pkg;

	localparam int DEFAULT_WORD_BITS = 32;
	localparam int FIELD_BITS = 32;
	localparam int CFG_INDEX_BITS = 4;
	localparam int DIGIT_BITS = 4;
	localparam int DIGITS = FIELD_BITS / DIGIT_BITS;
	localparam int CNT_BITS = $clog2(DIGITS);
	localparam int SAT_BITS = 42;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SAMPLE_PERIOD = 4'd0,
		REG_PLANT_GAIN    = 4'd1,
		REG_INV_GAIN      = 4'd2,
		REG_OBS_GAIN_ONE  = 4'd3,
		REG_OBS_GAIN_TWO  = 4'd4,
		REG_PROP_GAIN     = 4'd5,
		REG_DRIVE_MIN     = 4'd6,
		REG_DRIVE_MAX     = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] sample_period;
		logic signed [FIELD_BITS-1:0] plant_gain;
		logic signed [FIELD_BITS-1:0] inverse_plant_gain;
		logic signed [FIELD_BITS-1:0] observer_gain_one;
		logic signed [FIELD_BITS-1:0] observer_gain_two;
		logic signed [FIELD_BITS-1:0] proportional_gain;
		logic signed [FIELD_BITS-1:0] drive_minimum;
		logic signed [FIELD_BITS-1:0] drive_maximum;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic signed [FIELD_BITS-1:0] gain;
		logic signed [FIELD_BITS-1:0] sig;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic signed [FIELD_BITS-1:0] result;
	} mul_rsp_t;

	typedef struct packed {
		logic idle;
		logic push;
	} core_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED_D,
		ST_PRED_Z,
		ST_INNOV,
		ST_CORR_Z1,
		ST_CORR_Z2,
		ST_ERR,
		ST_LAW,
		ST_DRIVE,
		ST_OUT
	} core_state_t;

	// Saturate to the symmetric-plus-one signed range bounded by vmax.
	function automatic logic signed [FIELD_BITS-1:0] sat_sig(
		input logic signed [SAT_BITS-1:0] v,
		input logic signed [SAT_BITS-1:0] vmax
	);
		logic signed [SAT_BITS-1:0] vmin;
		logic signed [SAT_BITS-1:0] r;
		vmin = -vmax - 42'sd1;
		if (v > vmax) begin
			r = vmax;
		end else if (v < vmin) begin
			r = vmin;
		end else begin
			r = v;
		end
		return r[FIELD_BITS-1:0];
	endfunction

endpackage

[rtl/core/adrc_regs.sv]
`timescale 1ns / 1ps

module adrc_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [adrc_pkg::CFG_INDEX_BITS-1:0]  wr_index,
	input  logic [adrc_pkg::FIELD_BITS-1:0]      wr_data,
	output adrc_pkg::cfg_t                       cfg
);

	adrc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (adrc_pkg::cfg_reg_t'(wr_index))
				adrc_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period      <= $signed(wr_data);
				adrc_pkg::REG_PLANT_GAIN:    cfg_q.plant_gain         <= $signed(wr_data);
				adrc_pkg::REG_INV_GAIN:      cfg_q.inverse_plant_gain <= $signed(wr_data);
				adrc_pkg::REG_OBS_GAIN_ONE:  cfg_q.observer_gain_one  <= $signed(wr_data);
				adrc_pkg::REG_OBS_GAIN_TWO:  cfg_q.observer_gain_two  <= $signed(wr_data);
				adrc_pkg::REG_PROP_GAIN:     cfg_q.proportional_gain  <= $signed(wr_data);
				adrc_pkg::REG_DRIVE_MIN:     cfg_q.drive_minimum      <= $signed(wr_data);
				adrc_pkg::REG_DRIVE_MAX:     cfg_q.drive_maximum      <= $signed(wr_data);
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/adrc_mul.sv]
`timescale 1ns / 1ps

module adrc_mul #(
	parameter int WORD_BITS = adrc_pkg::DEFAULT_WORD_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  adrc_pkg::mul_req_t  req,
	output adrc_pkg::mul_rsp_t  rsp
);

	localparam int SIG_BITS = (WORD_BITS < adrc_pkg::FIELD_BITS) ? WORD_BITS
		: adrc_pkg::FIELD_BITS;
	localparam logic signed [adrc_pkg::SAT_BITS-1:0] SIG_MAX =
		(42'sd1 <<< (SIG_BITS - 1)) - 42'sd1;

	logic                        busy_q;
	logic                        fin_q;
	logic                        done_q;
	logic [adrc_pkg::CNT_BITS-1:0] cnt_q;
	logic signed [31:0]          gain_q;
	logic [31:0]                 sig_q;
	logic signed [32:0]          hi_q;
	logic [31:0]                 lo_q;
	logic signed [31:0]          res_q;

	logic                        last;
	logic signed [4:0]           dig_ext;
	logic signed [36:0]          pp;
	logic [36:0]                 sum;
	logic [40:0]                 full;
	logic [41:0]                 rnd;

	assign last = (cnt_q == adrc_pkg::CNT_BITS'(adrc_pkg::DIGITS - 1));

	// Lower digits are unsigned; the top digit carries the sign.
	assign dig_ext = last ? $signed({sig_q[3], sig_q[3:0]}) : $signed({1'b0, sig_q[3:0]});
	assign pp = gain_q * dig_ext;
	assign sum = {{4{hi_q[32]}}, hi_q} + pp;

	// Round to nearest, ties up: bit 23 of the product is the carry in.
	assign full = {hi_q, lo_q[31:24]};
	assign rnd = {full[40], full} + {41'd0, lo_q[23]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			gain_q <= req.gain;
			sig_q  <= req.sig;
			hi_q   <= '0;
			lo_q   <= '0;
		end else if (busy_q) begin
			hi_q  <= $signed(sum[36:4]);
			lo_q  <= {sum[3:0], lo_q[31:4]};
			sig_q <= {4'd0, sig_q[31:4]};
		end
		if (fin_q) begin
			res_q <= adrc_pkg::sat_sig($signed(rnd), SIG_MAX);
		end
	end

	assign rsp.busy   = busy_q | fin_q;
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

[rtl/core/adrc_core.sv]
`timescale 1ns / 1ps

module adrc_core #(
	parameter int WORD_BITS = adrc_pkg::DEFAULT_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adrc_pkg::cfg_t       cfg,
	input  logic                 go,
	input  logic signed [31:0]   reference,
	input  logic signed [31:0]   measurement,
	input  logic                 out_free,
	input  adrc_pkg::mul_rsp_t   mul_rsp,
	output adrc_pkg::mul_req_t   mul_req,
	output adrc_pkg::core_stat_t stat,
	output logic signed [31:0]   drive
);

	localparam int SIG_BITS = (WORD_BITS < adrc_pkg::FIELD_BITS) ? WORD_BITS
		: adrc_pkg::FIELD_BITS;
	localparam logic signed [adrc_pkg::SAT_BITS-1:0] SIG_MAX =
		(42'sd1 <<< (SIG_BITS - 1)) - 42'sd1;

	adrc_pkg::core_state_t state_q;
	adrc_pkg::core_state_t state_d;

	logic signed [31:0] z1_q;
	logic signed [31:0] z2_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] r_q;
	logic signed [31:0] y_q;
	logic signed [31:0] zp_q;
	logic signed [31:0] e_q;

	logic signed [31:0] alu_a;
	logic signed [31:0] alu_b;
	logic               alu_sub;
	logic signed [32:0] alu_sum;
	logic signed [31:0] alu_sat;
	logic signed [31:0] clamped;

	assign alu_sum = alu_sub ? (33'(alu_a) - 33'(alu_b)) : (33'(alu_a) + 33'(alu_b));
	assign alu_sat = adrc_pkg::sat_sig(42'(alu_sum), SIG_MAX);

	// Upper limit wins when the limits are inverted.
	always_comb begin
		priority if (mul_rsp.result > cfg.drive_maximum) begin
			clamped = cfg.drive_maximum;
		end else if (mul_rsp.result < cfg.drive_minimum) begin
			clamped = cfg.drive_minimum;
		end else begin
			clamped = mul_rsp.result;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			adrc_pkg::ST_IDLE:    if (go) state_d = adrc_pkg::ST_PRED_D;
			adrc_pkg::ST_PRED_D:  if (mul_rsp.done) state_d = adrc_pkg::ST_PRED_Z;
			adrc_pkg::ST_PRED_Z:  if (mul_rsp.done) state_d = adrc_pkg::ST_INNOV;
			adrc_pkg::ST_INNOV:   state_d = adrc_pkg::ST_CORR_Z1;
			adrc_pkg::ST_CORR_Z1: if (mul_rsp.done) state_d = adrc_pkg::ST_CORR_Z2;
			adrc_pkg::ST_CORR_Z2: if (mul_rsp.done) state_d = adrc_pkg::ST_ERR;
			adrc_pkg::ST_ERR:     state_d = adrc_pkg::ST_LAW;
			adrc_pkg::ST_LAW:     if (mul_rsp.done) state_d = adrc_pkg::ST_DRIVE;
			adrc_pkg::ST_DRIVE:   if (mul_rsp.done) state_d = adrc_pkg::ST_OUT;
			adrc_pkg::ST_OUT:     if (out_free) state_d = adrc_pkg::ST_IDLE;
			default:              state_d = adrc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		alu_a         = '0;
		alu_b         = '0;
		alu_sub       = 1'b0;
		mul_req.start = 1'b0;
		mul_req.gain  = '0;
		mul_req.sig   = '0;
		stat.push     = 1'b0;
		stat.idle     = (state_q == adrc_pkg::ST_IDLE);
		unique case (state_q)
			adrc_pkg::ST_IDLE: begin
				mul_req.start = go;
				mul_req.gain  = cfg.plant_gain;
				mul_req.sig   = prev_q;
			end
			adrc_pkg::ST_PRED_D: begin
				alu_a         = z2_q;
				alu_b         = mul_rsp.result;
				mul_req.start = mul_rsp.done;
				mul_req.gain  = cfg.sample_period;
				mul_req.sig   = alu_sat;
			end
			adrc_pkg::ST_PRED_Z: begin
				alu_a = z1_q;
				alu_b = mul_rsp.result;
			end
			adrc_pkg::ST_INNOV: begin
				alu_a         = y_q;
				alu_b         = zp_q;
				alu_sub       = 1'b1;
				mul_req.start = 1'b1;
				mul_req.gain  = cfg.observer_gain_one;
				mul_req.sig   = alu_sat;
			end
			adrc_pkg::ST_CORR_Z1: begin
				alu_a         = zp_q;
				alu_b         = mul_rsp.result;
				mul_req.start = mul_rsp.done;
				mul_req.gain  = cfg.observer_gain_two;
				mul_req.sig   = e_q;
			end
			adrc_pkg::ST_CORR_Z2: begin
				alu_a = z2_q;
				alu_b = mul_rsp.result;
			end
			adrc_pkg::ST_ERR: begin
				alu_a         = r_q;
				alu_b         = z1_q;
				alu_sub       = 1'b1;
				mul_req.start = 1'b1;
				mul_req.gain  = cfg.proportional_gain;
				mul_req.sig   = alu_sat;
			end
			adrc_pkg::ST_LAW: begin
				alu_a         = mul_rsp.result;
				alu_b         = z2_q;
				alu_sub       = 1'b1;
				mul_req.start = mul_rsp.done;
				mul_req.gain  = cfg.inverse_plant_gain;
				mul_req.sig   = alu_sat;
			end
			adrc_pkg::ST_DRIVE: begin
			end
			adrc_pkg::ST_OUT: begin
				stat.push = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adrc_pkg::ST_IDLE;
			z1_q    <= '0;
			z2_q    <= '0;
			prev_q  <= '0;
		end else begin
			state_q <= state_d;
			if (mul_rsp.done) begin
				if (state_q == adrc_pkg::ST_CORR_Z1) z1_q <= alu_sat;
				if (state_q == adrc_pkg::ST_CORR_Z2) z2_q <= alu_sat;
				// keep the clamped drive for the next prediction
				if (state_q == adrc_pkg::ST_DRIVE) prev_q <= clamped;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == adrc_pkg::ST_IDLE && go) begin
			r_q <= reference;
			y_q <= measurement;
		end
		if (state_q == adrc_pkg::ST_PRED_Z && mul_rsp.done) begin
			zp_q <= alu_sat;
		end
		if (state_q == adrc_pkg::ST_INNOV) begin
			e_q <= alu_sat;
		end
	end

	assign drive = prev_q;

endmodule

[rtl/core/first_order_adrc_controller.sv]
// One item at a time: the input is held off from an accepted item until its drive
// is pushed into the output register; six products go in turn through one radix-16
// digit-serial multiplier, each summed digit by digit, then rounded and saturated.
// Reset (arst_n low, asynchronous) zeroes the settings, both estimates, the previous
// drive and the control flags; datapath holding registers are left as they are.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_order_adrc_controller #(
	parameter int WORD_BITS = adrc_pkg::DEFAULT_WORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [31:0]                  reference,
	input  logic signed [31:0]                  measurement,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  drive,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [adrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [31:0]                         cfg_data
);

	adrc_pkg::cfg_t       cfg;
	adrc_pkg::mul_req_t   mul_req;
	adrc_pkg::mul_rsp_t   mul_rsp;
	adrc_pkg::core_stat_t stat;

	logic               in_accept;
	logic               out_free;
	logic               out_valid_q;
	logic signed [31:0] drive_q;
	logic signed [31:0] core_drive;
	logic               mul_clash;

	assign cfg_ready = 1'b1;
	assign in_stall  = !stat.idle;
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign mul_clash = mul_req.start && mul_rsp.busy;

	adrc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	adrc_mul #(
		.WORD_BITS (WORD_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	adrc_core #(
		.WORD_BITS (WORD_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.go          (in_accept),
		.reference   (reference),
		.measurement (measurement),
		.out_free    (out_free),
		.mul_rsp     (mul_rsp),
		.mul_req     (mul_req),
		.stat        (stat),
		.drive       (core_drive)
	);

	// Output register: hold the item until the far side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.push) begin
			drive_q <= core_drive;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_accept, in_stall, "input not held off")
	`ASSERT_IMPLY(a_mul_no_restart, clk, arst_n, mul_req.start, !mul_clash, "restart while busy")
	`ASSERT_IMPLY(a_push_slot_free, clk, arst_n, stat.push, out_free, "push onto full output")
	`ASSERT_NEXT(a_mul_done_order, clk, arst_n, mul_rsp.busy, !mul_clash, "multiplier overlap")

endmodule

[dv/drive_check_pkg.sv]
`timescale 1ns / 1ps

package drive_check_pkg;
	import adrc_pkg::*;

	localparam int REG_COUNT = int'(REG_DRIVE_MAX) + 1;
	localparam longint SIG_MAX = 64'sd2147483647;
	localparam longint SIG_MIN = -64'sd2147483648;
	localparam int GAIN_FRAC = 24;

	class drive_scoreboard;
		logic signed [FIELD_BITS-1:0] regs [REG_COUNT];
		logic signed [FIELD_BITS-1:0] output_est;
		logic signed [FIELD_BITS-1:0] disturbance_est;
		logic signed [FIELD_BITS-1:0] last_drive;
		logic signed [FIELD_BITS-1:0] expected_drive [$];
		int unsigned errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			output_est = '0;
			disturbance_est = '0;
			last_drive = '0;
			errors = 0;
		endfunction

		// Unknown indexes leave the settings alone.
		function void write_register(logic [CFG_INDEX_BITS-1:0] index, logic [31:0] data);
			if (index <= REG_DRIVE_MAX) begin
				regs[index] = data;
			end
		endfunction

		function longint clip(longint v);
			if (v > SIG_MAX) begin
				return SIG_MAX;
			end
			if (v < SIG_MIN) begin
				return SIG_MIN;
			end
			return v;
		endfunction

		// Q8.24 gain times Q16.16 signal, round half up, saturate.
		function longint scale(longint gain, longint sig);
			return clip((gain * sig + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC);
		endfunction

		function void accept_sample(logic signed [31:0] r, logic signed [31:0] y);
			longint s, zp, e, t, u;
			s = clip(longint'(disturbance_est) + scale(regs[REG_PLANT_GAIN], last_drive));
			zp = clip(longint'(output_est) + scale(regs[REG_SAMPLE_PERIOD], s));
			e = clip(longint'(y) - zp);
			output_est = 32'(clip(zp + scale(regs[REG_OBS_GAIN_ONE], e)));
			disturbance_est = 32'(clip(longint'(disturbance_est)
				+ scale(regs[REG_OBS_GAIN_TWO], e)));
			t = clip(scale(regs[REG_PROP_GAIN], clip(longint'(r) - longint'(output_est)))
				- longint'(disturbance_est));
			u = scale(regs[REG_INV_GAIN], t);
			// upper limit wins when the limits are crossed
			if (u > longint'(regs[REG_DRIVE_MAX])) begin
				u = regs[REG_DRIVE_MAX];
			end else if (u < longint'(regs[REG_DRIVE_MIN])) begin
				u = regs[REG_DRIVE_MIN];
			end
			last_drive = 32'(u);
			expected_drive.push_back(32'(u));
		endfunction

		function void check_drive(logic signed [31:0] actual);
			logic signed [31:0] want;
			if (expected_drive.size() == 0) begin
				$error("drive: expected none, actual %0d", actual);
				errors++;
			end else begin
				want = expected_drive.pop_front();
				if (actual !== want) begin
					$error("drive: expected %0d, actual %0d", want, actual);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_drive.size();
		endfunction
	endclass

endpackage

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import adrc_pkg::*;
	import drive_check_pkg::*;

	localparam logic signed [31:0] SIG_HI = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SIG_LO = 32'sh8000_0000;
	localparam int ONE_Q24 = 1 << 24;
	localparam int ONE_Q16 = 1 << 16;
	localparam int SIG_SPAN = 300 << 16;
	localparam int DRIVE_SPAN = 500 << 16;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 110;
	localparam int LONG_HOLD = 300;
	localparam int END_SETTLE = 80;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] reference = '0;
	logic signed [31:0] measurement = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] drive;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	bit source_gaps = 1'b1;
	bit sink_gaps = 1'b1;
	bit hold_sink = 1'b0;
	int unsigned quiet_cycles = 0;

	logic signed [31:0] corner_r [4] = '{SIG_HI, SIG_LO, SIG_HI, 32'sd0};
	logic signed [31:0] corner_y [4] = '{SIG_LO, SIG_HI, SIG_HI, 32'sd0};
	logic signed [31:0] boundary_values [4] = '{SIG_HI, SIG_LO, 32'sd0, -32'sd1};

	drive_scoreboard sb;

	first_order_adrc_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.reference(reference),
		.measurement(measurement),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive(drive),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_sample(input logic signed [31:0] r, input logic signed [31:0] y);
		int unsigned gap;
		gap = source_gaps ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		reference <= r;
		measurement <= y;
		do @(posedge clk); while (in_stall);
		sb.accept_sample(r, y);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(index, data);
	endtask

	task automatic load_settings(input cfg_t s);
		write_reg(REG_SAMPLE_PERIOD, s.sample_period);
		write_reg(REG_PLANT_GAIN, s.plant_gain);
		write_reg(REG_INV_GAIN, s.inverse_plant_gain);
		write_reg(REG_OBS_GAIN_ONE, s.observer_gain_one);
		write_reg(REG_OBS_GAIN_TWO, s.observer_gain_two);
		write_reg(REG_PROP_GAIN, s.proportional_gain);
		write_reg(REG_DRIVE_MIN, s.drive_minimum);
		write_reg(REG_DRIVE_MAX, s.drive_maximum);
		write_reg(CFG_INDEX_BITS'(REG_COUNT
			+ $urandom_range(0, (1 << CFG_INDEX_BITS) - 1 - REG_COUNT)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	// Hold the input off until every expected drive has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic cfg_t draw_settings(input int unsigned style);
		cfg_t s;
		s.sample_period = $urandom_range(0, ONE_Q24 / 20);
		s.plant_gain = $urandom_range(ONE_Q24 / 2, ONE_Q24 * 4);
		if ($urandom_range(0, 1)) begin
			s.plant_gain = -s.plant_gain;
		end
		s.inverse_plant_gain = 32'((64'sd1 <<< 48) / longint'(s.plant_gain));
		s.observer_gain_one = $urandom_range(0, ONE_Q24);
		s.observer_gain_two = $urandom_range(0, ONE_Q24 * 8);
		s.proportional_gain = $urandom_range(0, ONE_Q24 * 8);
		s.drive_minimum = 32'sd0 - $urandom_range(0, DRIVE_SPAN);
		s.drive_maximum = $urandom_range(0, DRIVE_SPAN);
		for (int i = 0; i < REG_COUNT; i++) begin
			if (style == 1 && $urandom_range(0, 3) == 0) begin
				s[i*32 +: 32] = $urandom;
			end else if (style == 2) begin
				case ($urandom_range(0, 3))
					0: s[i*32 +: 32] = SIG_HI;
					1: s[i*32 +: 32] = SIG_LO;
					2: s[i*32 +: 32] = '0;
					default: s[i*32 +: 32] = $urandom;
				endcase
			end
		end
		return s;
	endfunction

	function automatic logic signed [31:0] draw_signal();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 2 * SIG_SPAN) - SIG_SPAN;
			6, 7: return $urandom;
			8: return boundary_values[$urandom_range(0, 3)];
			default: return $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
		endcase
	endfunction

	initial begin
		int unsigned pause;
		wait (arst_n);
		forever begin
			if (hold_sink) begin
				pause = LONG_HOLD;
				hold_sink = 1'b0;
			end else begin
				pause = sink_gaps ? $urandom_range(0, 4) : 0;
			end
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_drive(drive);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		cfg_t nominal;
		cfg_t s;
		sb = new();
		nominal = '{
			sample_period: ONE_Q24 / 100,
			plant_gain: ONE_Q24,
			inverse_plant_gain: ONE_Q24,
			observer_gain_one: ONE_Q24 / 2,
			observer_gain_two: ONE_Q24 * 4,
			proportional_gain: ONE_Q24 * 2,
			drive_minimum: -(100 * ONE_Q16),
			drive_maximum: 100 * ONE_Q16
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every drive pinned to zero
		send_sample(SIG_HI, SIG_LO);
		send_sample(SIG_LO, SIG_HI);
		send_sample(32'sd0, 32'sd0);
		drain();

		load_settings(nominal);
		send_sample(10 * ONE_Q16, 32'sd0);
		send_sample(10 * ONE_Q16, 5 * ONE_Q16);
		send_sample(SIG_HI, SIG_LO);
		send_sample(SIG_LO, SIG_HI);
		send_sample(32'sd0, SIG_HI);
		send_sample(-32'sd1, 32'sd1);
		drain();

		// extreme gains at the signal limits, driven with corner inputs
		s = {REG_COUNT{SIG_HI}};
		s.drive_minimum = SIG_LO;
		load_settings(s);
		for (int i = 0; i < 4; i++) send_sample(corner_r[i], corner_y[i]);
		drain();
		s = {REG_COUNT{SIG_LO}};
		s.drive_maximum = SIG_HI;
		load_settings(s);
		for (int i = 0; i < 4; i++) send_sample(corner_r[i], corner_y[i]);
		drain();

		s = nominal;
		s.drive_minimum = 50 * ONE_Q16;
		s.drive_maximum = -(50 * ONE_Q16);
		load_settings(s);
		send_sample(20 * ONE_Q16, 32'sd0);
		send_sample(-(20 * ONE_Q16), 32'sd0);
		send_sample(32'sd0, 32'sd0);
		drain();

		// zero inverse gain: drive is zero before the clamp lifts it
		s = nominal;
		s.inverse_plant_gain = '0;
		s.drive_minimum = ONE_Q16;
		s.drive_maximum = 10 * ONE_Q16;
		load_settings(s);
		send_sample(20 * ONE_Q16, 32'sd0);
		send_sample(SIG_HI, SIG_LO);
		send_sample(32'sd0, 32'sd0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			load_settings(draw_settings(p % 3));
			source_gaps = (p % 4 != 3);
			sink_gaps = source_gaps;
			if (p % 5 == 1) begin
				hold_sink = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) send_sample(draw_signal(), draw_signal());
			drain();
		end

		repeat (END_SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/adrc_pkg.sv
rtl/core/adrc_regs.sv
rtl/core/adrc_mul.sv
rtl/core/adrc_core.sv
rtl/core/first_order_adrc_controller.sv
dv/drive_check_pkg.sv
dv/testbench.sv
